// ===== rtl/mwm_pkg.sv =====
package mwm_pkg;

   localparam int CMD_W = 16;
   // Sum of three commands needs two guard bits; its magnitude one bit less.
   localparam int SUM_W = CMD_W + 2;
   localparam int MAG_W = SUM_W - 1;
   localparam int LANES = 4;
   localparam int FRAC_BITS_DEFAULT = 14;

   localparam int LANE_FR = 0;
   localparam int LANE_FL = 1;
   localparam int LANE_BR = 2;
   localparam int LANE_BL = 3;

   localparam logic signed [31:0] CMD_MAX = 32'sd32767;
   localparam logic signed [31:0] CMD_MIN = -32'sd32768;

   typedef logic signed [SUM_W-1:0] wheel_type;
   typedef logic [MAG_W-1:0] mag_type;
   typedef logic [LANES-1:0][MAG_W-1:0] mag_vec_type;

   function automatic logic signed [CMD_W-1:0] sat_cmd(input logic signed [31:0] v);
      if (v > CMD_MAX) begin
         return CMD_W'(CMD_MAX);
      end else if (v < CMD_MIN) begin
         return CMD_W'(CMD_MIN);
      end else begin
         return CMD_W'(v);
      end
   endfunction

endpackage

// ===== rtl/mwm_divider.sv =====
module mwm_divider #(
   parameter int FRAC_BITS = mwm_pkg::FRAC_BITS_DEFAULT,
   parameter int SIDE_W = 1
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      en,
   input  logic                                      in_valid,
   input  mwm_pkg::mag_type                          in_top,
   input  mwm_pkg::mag_vec_type                      in_num,
   input  logic [SIDE_W-1:0]                         in_side,
   output logic                                      out_valid,
   output logic [mwm_pkg::LANES-1:0][FRAC_BITS:0]    out_quo,
   output logic [SIDE_W-1:0]                         out_side
);

   // One quotient bit per stage: (num << FRAC_BITS) / top with num <= top,
   // so the quotient never exceeds full scale and fits FRAC_BITS + 1 bits.
   localparam int STEPS = FRAC_BITS + 1;
   localparam int QUO_W = FRAC_BITS + 1;
   localparam int MAG_W = mwm_pkg::MAG_W;
   localparam int LANES = mwm_pkg::LANES;

   logic                              valid_ff [STEPS];
   logic [MAG_W-1:0]                  top_ff   [STEPS];
   logic [SIDE_W-1:0]                 side_ff  [STEPS];
   logic [LANES-1:0][MAG_W-1:0]       rem_ff   [STEPS];
   logic [LANES-1:0][QUO_W-1:0]       quo_ff   [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic                        prev_valid;
      logic [MAG_W-1:0]            prev_top;
      logic [SIDE_W-1:0]           prev_side;
      logic [LANES-1:0][MAG_W-1:0] prev_rem;
      logic [LANES-1:0][QUO_W-1:0] prev_quo;
      logic [LANES-1:0][MAG_W-1:0] rem_in;
      logic [LANES-1:0][QUO_W-1:0] quo_in;

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_top   = in_top;
         assign prev_side  = in_side;
         assign prev_rem   = in_num;
         assign prev_quo   = '0;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_top   = top_ff[k-1];
         assign prev_side  = side_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_quo   = quo_ff[k-1];
      end

      always_comb begin
         logic [MAG_W:0] trial;
         for (int l = 0; l < LANES; l++) begin
            // The first step tests the integer bit, later steps shift in a zero.
            trial = (k == 0) ? {1'b0, prev_rem[l]} : {prev_rem[l], 1'b0};
            if (trial >= {1'b0, prev_top}) begin
               rem_in[l] = MAG_W'(trial - {1'b0, prev_top});
               quo_in[l] = {prev_quo[l][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[l] = MAG_W'(trial);
               quo_in[l] = {prev_quo[l][QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= prev_valid;
         end
         if (en) begin
            top_ff[k]  <= prev_top;
            side_ff[k] <= prev_side;
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_quo   = quo_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

// ===== rtl/mecanum_wheel_mixer.sv =====
// Mecanum wheel mixer: turns one drive command into four wheel commands.
// The req channel carries one item per command (forward, strafe, turn, all
// signed Q1.14 with full scale at 1 << FRAC_BITS). The rsp channel returns
// one item per command with the four wheel drives in tdata and a flag in
// tuser that is set when the largest wheel magnitude exceeded full scale and
// all four were divided down to it.
// From acceptance to rsp_tvalid, one stage forms the wheel sums, three stages
// find the largest magnitude, FRAC_BITS + 1 stages run the restoring divider
// one quotient bit each, and one stage applies signs and saturates.
// Throughput is one item per cycle unless the output stalls. When the
// receiver holds rsp_tready low with a result waiting, the whole pipeline
// holds and req_tready drops, so no item is lost or repeated; an empty
// output register lets the pipeline keep moving. Reset clears every valid
// bit; no item is in flight afterwards.
module mecanum_wheel_mixer #(
   parameter int FRAC_BITS = mwm_pkg::FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // forward_cmd [15:0], strafe_cmd [31:16], turn_cmd [47:32]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // front_right_drive [15:0], front_left_drive [31:16],
   // back_right_drive [47:32], back_left_drive [63:48]
   output logic [63:0] rsp_tdata,
   // was_scaled [0]
   output logic        rsp_tuser
);

   localparam int CMD_W = mwm_pkg::CMD_W;
   localparam int SUM_W = mwm_pkg::SUM_W;
   localparam int MAG_W = mwm_pkg::MAG_W;
   localparam int LANES = mwm_pkg::LANES;
   localparam int QUO_W = FRAC_BITS + 1;
   localparam int SIDE_W = 1 + LANES * SUM_W;
   localparam logic [31:0] FULL_SCALE = 32'(1) << FRAC_BITS;

   logic en;

   mwm_pkg::wheel_type s1_wheel_in [LANES];
   logic               s1_valid_ff;
   mwm_pkg::wheel_type s1_wheel_ff [LANES];

   logic               s2_valid_ff;
   mwm_pkg::wheel_type s2_wheel_ff [LANES];
   mwm_pkg::mag_type   s2_mag_ff   [LANES];

   logic               s3_valid_ff;
   mwm_pkg::wheel_type s3_wheel_ff [LANES];
   mwm_pkg::mag_type   s3_mag_ff   [LANES];
   mwm_pkg::mag_type   s3_max_lo_ff;
   mwm_pkg::mag_type   s3_max_hi_ff;

   mwm_pkg::mag_type   s4_top_in;
   logic               s4_valid_ff;
   mwm_pkg::wheel_type s4_wheel_ff [LANES];
   mwm_pkg::mag_type   s4_mag_ff   [LANES];
   mwm_pkg::mag_type   s4_top_ff;
   logic               s4_scaled_ff;

   mwm_pkg::mag_vec_type           div_num;
   logic [SIDE_W-1:0]              div_side_in;
   logic                           div_valid;
   logic [LANES-1:0][QUO_W-1:0]    div_quo;
   logic [SIDE_W-1:0]              div_side_out;

   logic [63:0] rsp_data_in;
   logic        rsp_valid_ff;
   logic [63:0] rsp_data_ff;
   logic        rsp_scaled_ff;

   // The whole pipeline moves together unless a result is stuck at the output.
   assign en = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   always_comb begin
      mwm_pkg::wheel_type f;
      mwm_pkg::wheel_type s;
      mwm_pkg::wheel_type t;
      f = SUM_W'($signed(req_tdata[15:0]));
      s = SUM_W'($signed(req_tdata[31:16]));
      t = SUM_W'($signed(req_tdata[47:32]));
      s1_wheel_in[mwm_pkg::LANE_FR] = -(f + s + t);
      s1_wheel_in[mwm_pkg::LANE_FL] = f - s - t;
      s1_wheel_in[mwm_pkg::LANE_BR] = s - f - t;
      s1_wheel_in[mwm_pkg::LANE_BL] = f + s - t;
   end

   always_comb begin
      if (s3_max_lo_ff >= s3_max_hi_ff) begin
         s4_top_in = s3_max_lo_ff;
      end else begin
         s4_top_in = s3_max_hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            s1_wheel_ff[l] <= s1_wheel_in[l];
            s2_wheel_ff[l] <= s1_wheel_ff[l];
            s2_mag_ff[l]   <= s1_wheel_ff[l][SUM_W-1] ? MAG_W'(-s1_wheel_ff[l])
                                                      : MAG_W'(s1_wheel_ff[l]);
            s3_wheel_ff[l] <= s2_wheel_ff[l];
            s3_mag_ff[l]   <= s2_mag_ff[l];
            s4_wheel_ff[l] <= s3_wheel_ff[l];
            s4_mag_ff[l]   <= s3_mag_ff[l];
         end
         s3_max_lo_ff <= (s2_mag_ff[0] >= s2_mag_ff[1]) ? s2_mag_ff[0] : s2_mag_ff[1];
         s3_max_hi_ff <= (s2_mag_ff[2] >= s2_mag_ff[3]) ? s2_mag_ff[2] : s2_mag_ff[3];
         s4_top_ff    <= s4_top_in;
         s4_scaled_ff <= 32'(s4_top_in) > FULL_SCALE;
      end
   end

   always_comb begin
      div_side_in[0] = s4_scaled_ff;
      for (int l = 0; l < LANES; l++) begin
         div_num[l] = s4_mag_ff[l];
         div_side_in[1 + l*SUM_W +: SUM_W] = s4_wheel_ff[l];
      end
   end

   mwm_divider #(
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (SIDE_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_valid_ff),
      .in_top    (s4_top_ff),
      .in_num    (div_num),
      .in_side   (div_side_in),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side_out)
   );

   // When the item was scaled, every lane takes its signed quotient, else its own
   // sum; both saturate to the command width.
   always_comb begin
      mwm_pkg::wheel_type w;
      logic signed [31:0] q;
      logic signed [31:0] v;
      for (int l = 0; l < LANES; l++) begin
         w = div_side_out[1 + l*SUM_W +: SUM_W];
         q = $signed({{(32-QUO_W){1'b0}}, div_quo[l]});
         if (div_side_out[0]) begin
            v = w[SUM_W-1] ? -q : q;
         end else begin
            v = 32'(w);
         end
         rsp_data_in[l*CMD_W +: CMD_W] = mwm_pkg::sat_cmd(v);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_valid;
      end
      if (en) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_scaled_ff <= div_side_out[0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_scaled_ff;

endmodule
